@@ rtl/msg_pkg.sv @@
// shared constants, types and helper functions for the multi-axis step generator
// no dependencies
`timescale 1ns / 1ps

package msg_pkg;

  // number of axes driven by the core (1 to 6, the mask width)
  localparam int AXES = 6;

  localparam int AXIS_W   = 3;
  localparam int TARGET_W = 32;
  localparam int MAG_W    = 31;
  localparam int ACC_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int MASK_W   = 6;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // item kinds on the func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // per-lane control strobes
  typedef struct packed {
    logic load;
    logic tick;
  } lane_ctrl_t;

  // absolute value of a signed target, saturated to the magnitude width
  function automatic logic [MAG_W-1:0] magnitude_of(input logic [TARGET_W-1:0] raw);
    logic [TARGET_W-1:0] neg;
    neg = (~raw) + TARGET_W'(1);
    if (!raw[TARGET_W-1]) begin
      return raw[MAG_W-1:0];
    end else if (neg[TARGET_W-1]) begin
      return MAG_MAX;
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

@@ rtl/msg_if.sv @@
// valid/ready channel interfaces for the step generator input and result streams
// depends on msg_pkg
`timescale 1ns / 1ps

interface msg_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [msg_pkg::AXIS_W-1:0]        axis;
  logic signed [msg_pkg::TARGET_W-1:0] target;

  modport source (output valid, output func, output axis, output target, input ready);
  modport sink   (input valid, input func, input axis, input target, output ready);
endinterface

interface msg_out_if;
  logic                         valid;
  logic                         ready;
  logic [msg_pkg::MASK_W-1:0]   step_mask;
  logic [msg_pkg::MASK_W-1:0]   direction_mask;
  logic [msg_pkg::AXIS_W-1:0]   leading_axis;
  logic [msg_pkg::COUNT_W-1:0]  lead_count;

  modport source (output valid, output step_mask, output direction_mask,
                  output leading_axis, output lead_count, input ready);
  modport sink   (input valid, input step_mask, input direction_mask,
                  input leading_axis, input lead_count, output ready);
endinterface

@@ rtl/multi_axis_step_generator_core.sv @@
// top level of the multi-axis bresenham step generator
// depends on msg_pkg, msg_if (msg_in_if, msg_out_if) and msg_axis_lane
`timescale 1ns / 1ps

// Multi-axis line stepper. A line is set up with one load transaction per
// axis (func = 0), in axis order starting at axis 0; a load of axis 0 also
// restarts the tick count and the leader choice. Each tick transaction
// (func = 1) advances every axis by one bresenham step against the leading
// axis, the first axis with the strictly largest magnitude, and returns the
// axes that step. Every input transaction yields exactly one result
// transaction. Throughput is one transaction per clock while results are
// taken. The input register loads at the accepting edge and the result
// register when the input stage advances, which waits while a held result
// is not taken. The per-cycle work is set by each axis lane: one 32-bit
// add, one compare against the leader magnitude and one subtract. Loads of
// an axis beyond the configured count leave the state alone. Both channels
// use valid/ready.
module multi_axis_step_generator_core (
  input  logic        clk,
  input  logic        rst,
  msg_in_if.sink      in_ch,
  msg_out_if.source   out_ch
);

  // input register stage
  logic                          s1_valid;
  logic                          s1_func;
  logic [msg_pkg::AXIS_W-1:0]    s1_axis;
  logic [msg_pkg::TARGET_W-1:0]  s1_target;
  logic                          s1_adv;

  // line state
  logic [msg_pkg::AXES-1:0]      direction;
  logic [msg_pkg::AXIS_W-1:0]    leader;
  logic [msg_pkg::MAG_W-1:0]     lead_mag;
  logic [msg_pkg::COUNT_W-1:0]   tick_count;

  logic [msg_pkg::AXES-1:0]      direction_next;
  logic [msg_pkg::AXIS_W-1:0]    leader_next;
  logic [msg_pkg::MAG_W-1:0]     lead_mag_next;
  logic [msg_pkg::COUNT_W-1:0]   tick_count_next;
  logic [msg_pkg::MASK_W-1:0]    step_mask_next;
  logic [msg_pkg::MASK_W-1:0]    direction_mask_next;

  // result register
  logic                          out_valid;
  logic [msg_pkg::MASK_W-1:0]    step_mask;
  logic [msg_pkg::MASK_W-1:0]    direction_mask;

  // decoded item
  logic                          is_load;
  logic                          is_tick;
  logic                          axis_ok;
  logic                          do_load;
  logic [msg_pkg::MAG_W-1:0]     new_mag;

  // lanes
  msg_pkg::lane_ctrl_t           lane_ctrl [msg_pkg::AXES];
  logic [msg_pkg::MAG_W-1:0]     lane_mag  [msg_pkg::AXES];
  logic [msg_pkg::AXES-1:0]      lane_step;
  logic [msg_pkg::AXES-1:0]      lane_live;

  // the input stage moves on whenever the result register is free or drains
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func   <= in_ch.func;
      s1_axis   <= in_ch.axis;
      s1_target <= in_ch.target;
    end
  end

  assign is_load = s1_func == msg_pkg::FUNC_LOAD;
  assign is_tick = s1_func == msg_pkg::FUNC_TICK;
  assign axis_ok = 32'(s1_axis) < msg_pkg::AXES;
  assign do_load = s1_adv && is_load && axis_ok;
  assign new_mag = msg_pkg::magnitude_of(s1_target);

  // one lane per axis, each does its own add / compare / subtract
  for (genvar g = 0; g < msg_pkg::AXES; g++) begin : g_lane
    assign lane_ctrl[g].load = do_load && (s1_axis == msg_pkg::AXIS_W'(g));
    assign lane_ctrl[g].tick = s1_adv && is_tick;
    assign lane_live[g]      = lane_mag[g] != '0;

    msg_axis_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl[g]),
      .load_mag (new_mag),
      .lead_mag (lead_mag),
      .mag      (lane_mag[g]),
      .step     (lane_step[g])
    );
  end

  // next line state and the result fields
  always_comb begin
    direction_next  = direction;
    leader_next     = leader;
    lead_mag_next   = lead_mag;
    tick_count_next = tick_count;
    step_mask_next  = '0;

    if (is_tick) begin
      tick_count_next = tick_count + msg_pkg::COUNT_W'(1);
      for (int i = 0; i < msg_pkg::MASK_W; i++) begin
        if (i < msg_pkg::AXES) begin
          step_mask_next[i] = lane_step[i];
        end
      end
    end else if (axis_ok) begin
      direction_next[s1_axis] = s1_target[msg_pkg::TARGET_W-1];
      if (s1_axis == '0) begin
        // line start: axis 0 becomes the leader by default
        tick_count_next = '0;
        leader_next     = '0;
        lead_mag_next   = new_mag;
      end else if (new_mag > lead_mag) begin
        leader_next   = s1_axis;
        lead_mag_next = new_mag;
      end else if (s1_axis == leader) begin
        // reloading the leader with a smaller value keeps it the leader
        lead_mag_next = new_mag;
      end
    end

    direction_mask_next = '0;
    for (int i = 0; i < msg_pkg::MASK_W; i++) begin
      if (i < msg_pkg::AXES) begin
        direction_mask_next[i] = direction_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= '0;
      leader     <= '0;
      lead_mag   <= '0;
      tick_count <= '0;
    end else if (s1_adv) begin
      direction  <= direction_next;
      leader     <= leader_next;
      lead_mag   <= lead_mag_next;
      tick_count <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      step_mask      <= step_mask_next;
      direction_mask <= direction_mask_next;
    end
  end

  // leader and lead count are taken straight from the state registers,
  // which change only when a new result is loaded
  assign out_ch.valid          = out_valid;
  assign out_ch.step_mask      = step_mask;
  assign out_ch.direction_mask = direction_mask;
  assign out_ch.leading_axis   = leader;
  assign out_ch.lead_count     = tick_count;

  // leader always names a real axis
  a_leader_range: assert property (@(posedge clk) disable iff (rst)
    32'(leader) < msg_pkg::AXES)
    else $error("leader out of axis range");

  // an axis with zero magnitude never steps
  a_step_live: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && is_tick) |-> ((lane_step & ~lane_live) == '0))
    else $error("step on an idle axis");

  // a load of axis 0 restarts the tick count and the leader
  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (do_load && (s1_axis == '0)) |=> ((tick_count == '0) && (leader == '0)))
    else $error("line start did not clear tick count and leader");

  // a result sitting in the output register is stable while not taken
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(step_mask)
                                      && $stable(tick_count)))
    else $error("stalled result changed");

  // the input stage is never blocked while empty
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ch.ready)
    else $error("empty input stage refused a transaction");

endmodule

@@ rtl/msg_axis_lane.sv @@
// one axis of the bresenham stepper: magnitude and error accumulator
// depends on msg_pkg
`timescale 1ns / 1ps

module msg_axis_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  msg_pkg::lane_ctrl_t         ctrl,
  input  logic [msg_pkg::MAG_W-1:0]   load_mag,
  input  logic [msg_pkg::MAG_W-1:0]   lead_mag,
  output logic [msg_pkg::MAG_W-1:0]   mag,
  output logic                        step
);

  logic [msg_pkg::ACC_W-1:0] acc;
  logic [msg_pkg::ACC_W-1:0] sum;
  logic [msg_pkg::ACC_W-1:0] lead_ext;
  logic [msg_pkg::ACC_W-1:0] acc_next;

  always_comb begin
    lead_ext = msg_pkg::ACC_W'(lead_mag);
    sum      = acc + msg_pkg::ACC_W'(mag);
    step     = (lead_mag != '0) && (sum >= lead_ext);
    acc_next = step ? (sum - lead_ext) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag <= '0;
      acc <= '0;
    end else if (ctrl.load) begin
      mag <= load_mag;
      acc <= '0;
    end else if (ctrl.tick && (lead_mag != '0)) begin
      acc <= acc_next;
    end
  end

endmodule
